### rtl/core/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion with reset disable
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assertion also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### rtl/core/rpr_pkg.sv
// package: tables, types and helpers of the palette remapper
`default_nettype none
package rpr_pkg;
  localparam int SOURCE_ENTRIES = 64;
  localparam int MATCH_ENTRIES = 16;

  localparam logic [2:0] MODE_COMPOSITE = 3'd0;
  localparam logic [2:0] MODE_FOUR_GREEN = 3'd1;
  localparam logic [2:0] MODE_FOUR_RED = 3'd2;
  localparam logic [2:0] MODE_SIXTEEN_C64 = 3'd3;
  localparam logic [2:0] MODE_FOUR_CGA = 3'd4;
  localparam logic [2:0] MODE_SIXTEEN_EGA = 3'd5;
  localparam logic [2:0] MODE_RGB = 3'd6;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_LOW = 3'd1;
  localparam logic [2:0] REG_MID = 3'd2;
  localparam logic [2:0] REG_HIGH = 3'd3;
  localparam logic [2:0] REG_BLACK = 3'd4;

  localparam logic [15:0] CHROMA_K = 16'd43254;
  localparam logic [23:0] MASK_R = 24'hFFCCCC;
  localparam logic [23:0] MASK_G = 24'hCCFFCC;
  localparam logic [23:0] MASK_B = 24'hCCCCFF;
  localparam logic [23:0] MASK_NIB = 24'hF0F0F0;
  localparam logic [8:0] BIAS_MARGIN = 9'd10;

  typedef struct packed {
    logic [2:0] mode;
    logic [9:0] chroma_lo;
    logic [9:0] chroma_mid;
    logic [9:0] chroma_hi;
    logic [5:0] black_index;
  } cfg_t;

  // per-entry band (1..26) needs 5 bits
  typedef logic [4:0] band_t;

  function automatic logic [23:0] rom_rgb(input logic [5:0] i);
    logic [23:0] v;
    case (i)
      6'd0: v = 24'h7C7C7C; 6'd1: v = 24'h0000FC; 6'd2: v = 24'h0000BC; 6'd3: v = 24'h4428BC;
      6'd4: v = 24'h940084; 6'd5: v = 24'hA80020; 6'd6: v = 24'hA81000; 6'd7: v = 24'h881400;
      6'd8: v = 24'h503000; 6'd9: v = 24'h007800; 6'd10: v = 24'h006800; 6'd11: v = 24'h005800;
      6'd12: v = 24'h004058; 6'd16: v = 24'hBCBCBC; 6'd17: v = 24'h0078F8; 6'd18: v = 24'h0058F8;
      6'd19: v = 24'h6844FC; 6'd20: v = 24'hD800CC; 6'd21: v = 24'hE40058; 6'd22: v = 24'hF83800;
      6'd23: v = 24'hE45C10; 6'd24: v = 24'hAC7C00; 6'd25: v = 24'h00B800; 6'd26: v = 24'h00A800;
      6'd27: v = 24'h00A844; 6'd28: v = 24'h008888; 6'd32: v = 24'hF8F8F8; 6'd33: v = 24'h3CBCFC;
      6'd34: v = 24'h6888FC; 6'd35: v = 24'h9878F8; 6'd36: v = 24'hF878F8; 6'd37: v = 24'hF85898;
      6'd38: v = 24'hF87858; 6'd39: v = 24'hFCA044; 6'd40: v = 24'hF8B800; 6'd41: v = 24'hB8F818;
      6'd42: v = 24'h58D854; 6'd43: v = 24'h58F898; 6'd44: v = 24'h00E8D8; 6'd45: v = 24'h787878;
      6'd48: v = 24'hFCFCFC; 6'd49: v = 24'hA4E4FC; 6'd50: v = 24'hB8B8F8; 6'd51: v = 24'hD8B8F8;
      6'd52: v = 24'hF8B8F8; 6'd53: v = 24'hF8A4C0; 6'd54: v = 24'hF0D0B0; 6'd55: v = 24'hFCE0A8;
      6'd56: v = 24'hF8D878; 6'd57: v = 24'hD8F878; 6'd58: v = 24'hB8F8B8; 6'd59: v = 24'hB8F8D8;
      6'd60: v = 24'h00FCFC; 6'd61: v = 24'hF8D8F8;
      default: v = 24'h000000;
    endcase
    return v;
  endfunction

  function automatic logic [23:0] rom_comp(input logic [5:0] i);
    logic [23:0] v;
    case (i)
      6'd0: v = 24'h656565; 6'd1: v = 24'h00127D; 6'd2: v = 24'h18008E; 6'd3: v = 24'h360082;
      6'd4: v = 24'h56005D; 6'd5: v = 24'h5A0018; 6'd6: v = 24'h4F0500; 6'd7: v = 24'h381900;
      6'd8: v = 24'h1D3100; 6'd9: v = 24'h003D00; 6'd10: v = 24'h004100; 6'd11: v = 24'h003B17;
      6'd12: v = 24'h002E55; 6'd16: v = 24'hAFAFAF; 6'd17: v = 24'h194EC8; 6'd18: v = 24'h472FE3;
      6'd19: v = 24'h6B1FD7; 6'd20: v = 24'h931BAE; 6'd21: v = 24'h9E1A5E; 6'd22: v = 24'h993200;
      6'd23: v = 24'h7B4B00; 6'd24: v = 24'h5B6700; 6'd25: v = 24'h267A00; 6'd26: v = 24'h008200;
      6'd27: v = 24'h007A3E; 6'd28: v = 24'h006E8A; 6'd32: v = 24'hFFFFFF; 6'd33: v = 24'h64A9FF;
      6'd34: v = 24'h8E89FF; 6'd35: v = 24'hB676FF; 6'd36: v = 24'hE06FFF; 6'd37: v = 24'hEF6CC4;
      6'd38: v = 24'hF0806A; 6'd39: v = 24'hD8982C; 6'd40: v = 24'hB9B40A; 6'd41: v = 24'h83CB0C;
      6'd42: v = 24'h5BD63F; 6'd43: v = 24'h4AD17E; 6'd44: v = 24'h4DC7CB; 6'd45: v = 24'h4C4C4C;
      6'd48: v = 24'hFFFFFF; 6'd49: v = 24'hC7E5FF; 6'd50: v = 24'hD9D9FF; 6'd51: v = 24'hE9D1FF;
      6'd52: v = 24'hF9CEFF; 6'd53: v = 24'hFFCCF1; 6'd54: v = 24'hFFD4CB; 6'd55: v = 24'hF8DFB1;
      6'd56: v = 24'hEDEAA4; 6'd57: v = 24'hD6F4A4; 6'd58: v = 24'hC5F8B8; 6'd59: v = 24'hBEF6D3;
      6'd60: v = 24'hBFF1F1; 6'd61: v = 24'hB9B9B9;
      default: v = 24'h000000;
    endcase
    return v;
  endfunction

  function automatic logic [23:0] four_color(input logic [2:0] mode, input logic [1:0] i);
    logic [23:0] v;
    case (mode)
      MODE_FOUR_GREEN: begin
        case (i)
          2'd0: v = 24'hE0F8D0; 2'd1: v = 24'h88C070; 2'd2: v = 24'h306850;
          default: v = 24'h081820;
        endcase
      end
      MODE_FOUR_RED: begin
        case (i)
          2'd0: v = 24'hFF0000; 2'd1: v = 24'hA10000; 2'd2: v = 24'h400000;
          default: v = 24'h000000;
        endcase
      end
      default: begin
        case (i)
          2'd0: v = 24'hFFFFFF; 2'd1: v = 24'h00FFFF; 2'd2: v = 24'hFF00FF;
          default: v = 24'h000000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [23:0] match_color(input logic ega, input logic [3:0] i);
    logic [23:0] v;
    if (ega) begin
      case (i)
        4'd0: v = 24'h000000; 4'd1: v = 24'h0000AA; 4'd2: v = 24'h00AA00; 4'd3: v = 24'h00AAAA;
        4'd4: v = 24'hAA0000; 4'd5: v = 24'hAA00AA; 4'd6: v = 24'hAA5500; 4'd7: v = 24'hAAAAAA;
        4'd8: v = 24'h555555; 4'd9: v = 24'h5555FF; 4'd10: v = 24'h55FF55; 4'd11: v = 24'h55FFFF;
        4'd12: v = 24'hFF5555; 4'd13: v = 24'hFF55FF; 4'd14: v = 24'hFFFF55;
        default: v = 24'hFFFFFF;
      endcase
    end else begin
      case (i)
        4'd0: v = 24'h000000; 4'd1: v = 24'hFFFFFF; 4'd2: v = 24'h883932; 4'd3: v = 24'h67B6BD;
        4'd4: v = 24'h8B3F96; 4'd5: v = 24'h55A049; 4'd6: v = 24'h40318D; 4'd7: v = 24'hBFCE72;
        4'd8: v = 24'h8B5429; 4'd9: v = 24'h574200; 4'd10: v = 24'hB86962; 4'd11: v = 24'h505050;
        4'd12: v = 24'h787878; 4'd13: v = 24'h94E089; 4'd14: v = 24'h7869C4;
        default: v = 24'h9F9F9F;
      endcase
    end
    return v;
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // max(1, ceil(m / 10)) for m up to 255, by threshold compare
  function automatic band_t band_of(input logic [7:0] m);
    band_t n;
    n = 5'd1;
    for (int k = 1; k <= 25; k++) begin
      if ({1'b0, m} > 9'(k * 10)) n = 5'(k + 1);
    end
    return n;
  endfunction
endpackage
`default_nettype wire

### rtl/core/retro_palette_remapper_top.sv
// top level: config registers and three-stage remap pipeline
// an accepted item passes the stage one, two and three registers on its way to output valid
// pipeline throughput is one item per cycle while the output is not stalled, set by the three-stage register pipeline
// stall: whole pipeline holds when output is valid and not taken
// reset: synchronous rst clears valid bits and loads register defaults
`default_nettype none
module retro_palette_remapper_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // color_index
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // rgb_color[23:0], index_clamped, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  rpr_pkg::cfg_t cfg;
  logic en;
  logic v1, clamped1, v2, clamped2, v3;
  logic [23:0] direct1, biased1, direct2;
  logic [25:0] chroma_sum1;
  logic [1:0] four2;
  rpr_pkg::band_t bands2 [rpr_pkg::MATCH_ENTRIES];
  logic [24:0] data3;

  // pipeline advances unless the output holds an untaken item
  assign en = !v3 || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = v3;
  assign m_axis_tdata = {7'd0, data3};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= rpr_pkg::MODE_COMPOSITE;
      cfg.chroma_lo <= 10'd120;
      cfg.chroma_mid <= 10'd240;
      cfg.chroma_hi <= 10'd360;
      cfg.black_index <= 6'd63;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpr_pkg::REG_MODE: cfg.mode <= cfg_data[2:0];
        rpr_pkg::REG_LOW: cfg.chroma_lo <= cfg_data;
        rpr_pkg::REG_MID: cfg.chroma_mid <= cfg_data;
        rpr_pkg::REG_HIGH: cfg.chroma_hi <= cfg_data;
        rpr_pkg::REG_BLACK: cfg.black_index <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // stage one: clamp, rom and chroma product
  rpr_front u_front (
    .clk, .rst, .en, .in_valid(s_axis_tvalid), .color_index(s_axis_tdata), .cfg,
    .v1, .clamped1, .direct1, .chroma_sum1, .biased1
  );

  // stage two: chroma banding and distance bands
  rpr_match u_match (
    .clk, .rst, .en, .cfg, .v1, .clamped1, .direct1, .chroma_sum1, .biased1,
    .v2, .clamped2, .direct2, .four2, .bands2
  );

  // stage three: nearest entry and output register
  rpr_select u_select (
    .clk, .rst, .en, .cfg, .v2, .clamped2, .direct2, .four2, .bands2, .v3, .data3
  );
endmodule
`default_nettype wire

### rtl/core/rpr_front.sv
// front stage: clamp, rom read, chroma product and colour bias
`default_nettype none
module rpr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [7:0]    color_index,
  input  wire rpr_pkg::cfg_t cfg,
  output logic               v1,
  output logic               clamped1,
  output logic [23:0]        direct1,
  output logic [25:0]        chroma_sum1,
  output logic [23:0]        biased1
);
  logic [5:0] idx;
  logic [23:0] src, nib, bc;
  logic [7:0] r, g, b;

  always_comb begin
    idx = (color_index > 8'd63) ? cfg.black_index : color_index[5:0];
    src = rpr_pkg::rom_rgb(idx);
    nib = src & rpr_pkg::MASK_NIB;
    r = src[23:16];
    g = src[15:8];
    b = src[7:0];
    bc = src;
    if (r > g) begin
      if (r > b && ({1'b0, r} + rpr_pkg::BIAS_MARGIN) > ({1'b0, g} + {1'b0, b}))
        bc = src & rpr_pkg::MASK_R;
    end else if (g > b) begin
      if (({1'b0, g} + rpr_pkg::BIAS_MARGIN) > ({1'b0, r} + {1'b0, b}))
        bc = src & rpr_pkg::MASK_G;
    end else begin
      if (({1'b0, b} + rpr_pkg::BIAS_MARGIN) > ({1'b0, g} + {1'b0, r}))
        bc = src & rpr_pkg::MASK_B;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      clamped1 <= color_index > 8'd63;
      direct1 <= (cfg.mode == rpr_pkg::MODE_COMPOSITE) ? rpr_pkg::rom_comp(idx) : src;
      chroma_sum1 <= {2'b00, nib[15:8], 16'h0000}
                     + ({17'd0, {1'b0, nib[23:16]} + {1'b0, nib[7:0]}}
                        * {10'd0, rpr_pkg::CHROMA_K});
      biased1 <= bc & rpr_pkg::MASK_NIB;
    end
  end
endmodule
`default_nettype wire

### rtl/core/rpr_match.sv
// middle stage: chroma band and per-entry match bands
`default_nettype none
module rpr_match (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire rpr_pkg::cfg_t cfg,
  input  wire logic          v1,
  input  wire logic          clamped1,
  input  wire logic [23:0]   direct1,
  input  wire logic [25:0]   chroma_sum1,
  input  wire logic [23:0]   biased1,
  output logic               v2,
  output logic               clamped2,
  output logic [23:0]        direct2,
  output logic [1:0]         four2,
  output rpr_pkg::band_t     bands2 [rpr_pkg::MATCH_ENTRIES]
);
  logic [9:0] chroma;
  logic [1:0] four;
  rpr_pkg::band_t bands [rpr_pkg::MATCH_ENTRIES];
  logic ega;

  always_comb begin
    chroma = chroma_sum1[25:16];
    if (chroma <= cfg.chroma_lo) four = 2'd3;
    else if (chroma <= cfg.chroma_mid) four = 2'd2;
    else if (chroma <= cfg.chroma_hi) four = 2'd1;
    else four = 2'd0;
    ega = cfg.mode == rpr_pkg::MODE_SIXTEEN_EGA;
    for (int i = 0; i < rpr_pkg::MATCH_ENTRIES; i++) begin
      logic [23:0] p;
      logic [7:0] m, d1, d2;
      p = rpr_pkg::match_color(ega, 4'(i));
      m = rpr_pkg::abs_diff(biased1[23:16], p[23:16]);
      d1 = rpr_pkg::abs_diff(biased1[15:8], p[15:8]);
      d2 = rpr_pkg::abs_diff(biased1[7:0], p[7:0]);
      if (d1 > m) m = d1;
      if (d2 > m) m = d2;
      bands[i] = rpr_pkg::band_of(m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      clamped2 <= clamped1;
      direct2 <= direct1;
      four2 <= four;
      bands2 <= bands;
    end
  end
endmodule
`default_nettype wire

### rtl/core/rpr_select.sv
// last stage: lowest band search and final colour select
`default_nettype none
module rpr_select (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire rpr_pkg::cfg_t cfg,
  input  wire logic          v2,
  input  wire logic          clamped2,
  input  wire logic [23:0]   direct2,
  input  wire logic [1:0]    four2,
  input  wire rpr_pkg::band_t bands2 [rpr_pkg::MATCH_ENTRIES],
  output logic               v3,
  output logic [24:0]        data3
);
  // two-level tree: four groups of four, then the winners
  logic [3:0] gi [4];
  rpr_pkg::band_t gb [4];
  logic [3:0] best;
  rpr_pkg::band_t bb;
  logic [23:0] rgb;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      gi[g] = 4'(g * 4);
      gb[g] = bands2[g * 4];
      for (int k = 1; k < 4; k++) begin
        if (bands2[g * 4 + k] < gb[g]) begin
          gb[g] = bands2[g * 4 + k];
          gi[g] = 4'(g * 4 + k);
        end
      end
    end
    best = gi[0];
    bb = gb[0];
    for (int g = 1; g < 4; g++) begin
      if (gb[g] < bb) begin
        bb = gb[g];
        best = gi[g];
      end
    end
    case (cfg.mode)
      rpr_pkg::MODE_FOUR_GREEN, rpr_pkg::MODE_FOUR_RED, rpr_pkg::MODE_FOUR_CGA:
        rgb = rpr_pkg::four_color(cfg.mode, four2);
      rpr_pkg::MODE_SIXTEEN_C64: rgb = rpr_pkg::match_color(1'b0, best);
      rpr_pkg::MODE_SIXTEEN_EGA: rgb = rpr_pkg::match_color(1'b1, best);
      default: rgb = direct2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      data3 <= {clamped2, rgb};
    end
  end
endmodule
`default_nettype wire

### rtl/core/rpr_checker.sv
// port-level checker for the remapper, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module rpr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);
  `ASSERT_CLK(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output dropped")
  `ASSERT_CLK(a_ready, clk, rst, !m_axis_tvalid |-> s_axis_tready, "not ready while empty")
  `ASSERT_CLK(a_pad, clk, rst, m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0, "pad bits set")
  `ASSERT_ALWAYS(a_rst, clk, rst |=> !m_axis_tvalid, "valid after reset")
endmodule
bind retro_palette_remapper_top rpr_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
